// File: rtl/core/pushbutton_debounce_autorepeat_defines.svh
// Assertion macros used by the RTL of the push-button qualifier.
`ifndef PUSHBUTTON_DEBOUNCE_AUTOREPEAT_DEFINES_SVH
`define PUSHBUTTON_DEBOUNCE_AUTOREPEAT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PBDA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pbda_pkg.sv
`timescale 1ns / 1ps

package pbda_pkg;

    // Fixed field widths
    localparam int CFG_W    = 16;
    localparam int MASK_W   = 8;
    localparam int BTN_W    = 3;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REG_IX_W = 3;

    // Item kinds
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IX_W-1:0] REG_RC_SLOW = 3'd0;
    localparam logic [REG_IX_W-1:0] REG_RC_FAST = 3'd1;
    localparam logic [REG_IX_W-1:0] REG_WT_SLOW = 3'd2;
    localparam logic [REG_IX_W-1:0] REG_WT_FAST = 3'd3;
    localparam logic [REG_IX_W-1:0] REG_MASK    = 3'd4;

    // Register values after reset
    localparam logic [CFG_W-1:0]  RST_RC_SLOW = 16'd3;
    localparam logic [CFG_W-1:0]  RST_RC_FAST = 16'd1;
    localparam logic [CFG_W-1:0]  RST_WT_SLOW = 16'd50;
    localparam logic [CFG_W-1:0]  RST_WT_FAST = 16'd20;
    localparam logic [MASK_W-1:0] RST_MASK    = 8'd0;

    // Configuration handed from the register file to the datapath
    typedef struct packed {
        logic [CFG_W-1:0]  repeat_count_slow;
        logic [CFG_W-1:0]  repeat_count_fast;
        logic [CFG_W-1:0]  wait_ticks_slow;
        logic [CFG_W-1:0]  wait_ticks_fast;
        logic [MASK_W-1:0] slow_class_mask;
    } t_cfg;

endpackage

// File: rtl/core/pushbutton_debounce_autorepeat.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+----------------------------------
// in       | input     | i_in_valid / o_in_stall      | i_req_type, i_button_index, i_level
// out      | output    | o_out_valid / i_out_stall    | o_result_button, o_pressed
// cfg      | input     | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One item per cycle while o_in_stall is low; a sample passes the input register,
// then its result is loaded into the output register. The input register feeds the
// update logic on the per-button counter and timer registers; ticks update all
// timers at once and give no beat. Reset (synchronous, active low) clears all
// counters and timers at once. A stalled output holds its beat; the input stage
// then holds a sample until the output frees, while a tick always passes through.

module pushbutton_debounce_autorepeat #(
    parameter int NUM_BUTTONS = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_req_type,
    input  logic [pbda_pkg::BTN_W-1:0]  i_button_index,
    input  logic                        i_level,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [pbda_pkg::BTN_W-1:0]  o_result_button,
    output logic                        o_pressed,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbda_pkg::ADDR_W-1:0] paddr,
    input  logic [pbda_pkg::DATA_W-1:0] pwdata,
    output logic [pbda_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    import pbda_pkg::*;

`include "pushbutton_debounce_autorepeat_defines.svh"

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    t_cfg cfg;

    // Input stage
    logic             r_s1_valid;
    logic             r_s1_req;
    logic [BTN_W-1:0] r_s1_button;
    logic             r_s1_level;

    // Output stage
    logic             r_out_valid;
    logic [BTN_W-1:0] r_out_button;
    logic             r_out_pressed;

    // Per-button state
    logic [COUNT_WIDTH-1:0] r_count [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] r_timer [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] n_count [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] n_timer [NUM_BUTTONS];

    logic                   out_free;
    logic                   s1_fire;
    logic                   in_accept;
    logic                   is_sample;
    logic                   in_range;
    logic [IDX_W-1:0]       sel;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] cur_timer;
    logic                   hit;
    logic                   press;
    logic                   slow;
    logic [COUNT_WIDTH-1:0] reload_count;
    logic [COUNT_WIDTH-1:0] reload_timer;

    pbda_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshake: ticks never wait on the output side
    assign is_sample  = (r_s1_req == REQ_SAMPLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && (!is_sample || out_free);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Select the sampled button's state
    assign in_range  = (32'(r_s1_button) < NUM_BUTTONS);
    assign sel       = in_range ? IDX_W'(r_s1_button) : '0;
    assign cur_count = r_count[sel];
    assign cur_timer = r_timer[sel];
    assign hit       = is_sample && in_range && !r_s1_level && (cur_timer == '0);
    assign press     = hit && (cur_count == '0);

    // Pick the class reload values
    assign slow         = cfg.slow_class_mask[r_s1_button];
    assign reload_count = slow ? COUNT_WIDTH'(cfg.repeat_count_slow)
                               : COUNT_WIDTH'(cfg.repeat_count_fast);
    assign reload_timer = slow ? COUNT_WIDTH'(cfg.wait_ticks_slow)
                               : COUNT_WIDTH'(cfg.wait_ticks_fast);

    // Next state of every button
    always_comb begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            n_count[b] = r_count[b];
            n_timer[b] = r_timer[b];
            if (s1_fire && !is_sample && (r_timer[b] != '0)) begin
                n_timer[b] = r_timer[b] - COUNT_WIDTH'(1);
            end
            if (s1_fire && hit && (IDX_W'(b) == sel)) begin
                if (press) begin
                    n_count[b] = reload_count;
                    n_timer[b] = reload_timer;
                end else begin
                    n_count[b] = r_count[b] - COUNT_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_count[b] <= '0;
                r_timer[b] <= '0;
            end
        end else begin
            r_count <= n_count;
            r_timer <= n_timer;
        end
    end

    // Load the input stage, drop it once processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_req    <= i_req_type;
            r_s1_button <= i_button_index;
            r_s1_level  <= i_level;
        end
    end

    // Output beat: load on a sample, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && is_sample) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && is_sample) begin
            r_out_button  <= r_s1_button;
            r_out_pressed <= press;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_button = r_out_button;
    assign o_pressed       = r_out_pressed;

    // Checks
    `PBDA_ASSERT_NEXT(a_sample_gives_beat, i_clk, i_rst_n,
        s1_fire && is_sample,
        r_out_valid && (r_out_button == $past(r_s1_button)),
        "sample did not produce its beat")
    `PBDA_ASSERT_NEXT(a_press_reported, i_clk, i_rst_n,
        s1_fire && press,
        r_out_pressed && (r_count[$past(sel)] == $past(reload_count)),
        "qualified press not reported or counter not reloaded")
    `PBDA_ASSERT_NEXT(a_held_item_kept, i_clk, i_rst_n,
        r_s1_valid && !s1_fire,
        r_s1_valid && $stable(r_s1_button) && $stable(r_s1_req),
        "held input item lost or changed")
    `PBDA_ASSERT_NOW(a_tick_never_stalls, i_clk, i_rst_n,
        r_s1_valid && !is_sample,
        !o_in_stall,
        "tick held in the input stage")

endmodule

// File: rtl/core/pbda_regs.sv
`timescale 1ns / 1ps

module pbda_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbda_pkg::ADDR_W-1:0] paddr,
    input  logic [pbda_pkg::DATA_W-1:0] pwdata,
    output logic [pbda_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output pbda_pkg::t_cfg              o_cfg
);

    import pbda_pkg::*;

    t_cfg                r_cfg;
    logic                wr_en;
    logic [REG_IX_W-1:0] reg_ix;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign reg_ix = paddr[ADDR_W-1:2];

    // Write on the access phase; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_count_slow <= RST_RC_SLOW;
            r_cfg.repeat_count_fast <= RST_RC_FAST;
            r_cfg.wait_ticks_slow   <= RST_WT_SLOW;
            r_cfg.wait_ticks_fast   <= RST_WT_FAST;
            r_cfg.slow_class_mask   <= RST_MASK;
        end else if (wr_en) begin
            unique case (reg_ix)
                REG_RC_SLOW: r_cfg.repeat_count_slow <= pwdata[CFG_W-1:0];
                REG_RC_FAST: r_cfg.repeat_count_fast <= pwdata[CFG_W-1:0];
                REG_WT_SLOW: r_cfg.wait_ticks_slow   <= pwdata[CFG_W-1:0];
                REG_WT_FAST: r_cfg.wait_ticks_fast   <= pwdata[CFG_W-1:0];
                REG_MASK:    r_cfg.slow_class_mask   <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_ix)
            REG_RC_SLOW: prdata = DATA_W'(r_cfg.repeat_count_slow);
            REG_RC_FAST: prdata = DATA_W'(r_cfg.repeat_count_fast);
            REG_WT_SLOW: prdata = DATA_W'(r_cfg.wait_ticks_slow);
            REG_WT_FAST: prdata = DATA_W'(r_cfg.wait_ticks_fast);
            REG_MASK:    prdata = DATA_W'(r_cfg.slow_class_mask);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: test/tb_pushbutton_debounce_autorepeat.sv
`timescale 1ns / 1ps

module tb_pushbutton_debounce_autorepeat;
    import pbda_pkg::*;

    localparam int NUM_BUTTONS     = 8;
    localparam int COUNT_WIDTH     = 16;
    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 10;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int HOLD_AT_ITEM    = 80;
    localparam int HOLD_CYCLES     = 80;
    localparam int QUIET_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_LIMIT     = 4000;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;
    typedef enum logic {CHK_MODEL, CHK_TYPED} t_chk_kind;

    typedef struct {
        t_row_kind             kind;
        logic                  req;
        logic [BTN_W-1:0]      idx;
        logic                  lvl;
        t_chk_kind             chk;
        logic                  exp_pressed;
        logic [REG_IX_W-1:0]   reg_ix;
        logic [DATA_W-1:0]     value;
    } t_stim_row;

    typedef struct packed {
        logic [BTN_W-1:0] button;
        logic             pressed;
    } t_press;

    // Clock, reset and block inputs, all known from time zero
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                i_req_type     = REQ_TICK;
    logic [BTN_W-1:0]    i_button_index = '0;
    logic                i_level        = 1'b1;
    logic                i_out_stall    = 1'b0;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [ADDR_W-1:0]   paddr          = '0;
    logic [DATA_W-1:0]   pwdata         = '0;

    logic                o_in_stall;
    logic                o_out_valid;
    logic [BTN_W-1:0]    o_result_button;
    logic                o_pressed;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Shadow copy of the per-button state and the class settings
    logic [COUNT_WIDTH-1:0] count_left [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] wait_left  [NUM_BUTTONS];
    logic [CFG_W-1:0]       rc_slow    = RST_RC_SLOW;
    logic [CFG_W-1:0]       rc_fast    = RST_RC_FAST;
    logic [CFG_W-1:0]       wt_slow    = RST_WT_SLOW;
    logic [CFG_W-1:0]       wt_fast    = RST_WT_FAST;
    logic [MASK_W-1:0]      class_mask = RST_MASK;

    t_press    expected_presses [$];
    t_stim_row stim_rows [$];

    int check_failures  = 0;
    int results_seen    = 0;
    int presses_seen    = 0;
    int items_sent      = 0;
    int ticks_sent      = 0;
    int writes_done     = 0;
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int quiet_cycles    = 0;
    logic hold_active   = 1'b0;

    pushbutton_debounce_autorepeat #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_button_index  (i_button_index),
        .i_level         (i_level),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_button (o_result_button),
        .o_pressed       (o_pressed),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Advance the shadow state by one accepted item
    task automatic qualify_press(input logic req, input logic [BTN_W-1:0] idx,
                                 input logic lvl, output logic has_result,
                                 output logic pressed);
        has_result = (req == REQ_SAMPLE);
        pressed    = 1'b0;
        if (req == REQ_TICK) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (wait_left[b] != '0) begin
                    wait_left[b] = wait_left[b] - 1'b1;
                end
            end
        end else if (lvl == 1'b0 && wait_left[idx] == '0) begin
            if (count_left[idx] != '0) begin
                count_left[idx] = count_left[idx] - 1'b1;
            end else begin
                if (class_mask[idx]) begin
                    count_left[idx] = rc_slow;
                    wait_left[idx]  = wt_slow;
                end else begin
                    count_left[idx] = rc_fast;
                    wait_left[idx]  = wt_fast;
                end
                pressed = 1'b1;
            end
        end
    endtask

    // Mirror a register write; writes beyond the list change nothing
    task automatic note_register_write(input logic [REG_IX_W-1:0] ix,
                                       input logic [DATA_W-1:0] value);
        case (ix)
            REG_RC_SLOW: rc_slow = value[CFG_W-1:0];
            REG_RC_FAST: rc_fast = value[CFG_W-1:0];
            REG_WT_SLOW: wt_slow = value[CFG_W-1:0];
            REG_WT_FAST: wt_fast = value[CFG_W-1:0];
            REG_MASK:    class_mask = value[MASK_W-1:0];
            default: ;
        endcase
    endtask

    function automatic void add_item(input logic req, input int idx, input logic lvl,
                                     input t_chk_kind chk, input logic exp_pressed);
        t_stim_row row;
        row.kind        = ROW_ITEM;
        row.req         = req;
        row.idx         = BTN_W'(idx);
        row.lvl         = lvl;
        row.chk         = chk;
        row.exp_pressed = exp_pressed;
        row.reg_ix      = '0;
        row.value       = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_write(input logic [REG_IX_W-1:0] ix,
                                      input logic [DATA_W-1:0] value);
        t_stim_row row;
        row.kind        = ROW_WRITE;
        row.req         = REQ_TICK;
        row.idx         = '0;
        row.lvl         = 1'b1;
        row.chk         = CHK_MODEL;
        row.exp_pressed = 1'b0;
        row.reg_ix      = ix;
        row.value       = value;
        stim_rows.push_back(row);
    endfunction

    // Queue a full setting, junk in the upper bits, plus writes to the spare slots
    function automatic void add_setting(input logic [CFG_W-1:0] rcs,
                                        input logic [CFG_W-1:0] rcf,
                                        input logic [CFG_W-1:0] wts,
                                        input logic [CFG_W-1:0] wtf,
                                        input logic [MASK_W-1:0] mask);
        add_write(REG_RC_SLOW, ($urandom << CFG_W) | DATA_W'(rcs));
        add_write(REG_RC_FAST, ($urandom << CFG_W) | DATA_W'(rcf));
        add_write(REG_WT_SLOW, ($urandom << CFG_W) | DATA_W'(wts));
        add_write(REG_WT_FAST, ($urandom << CFG_W) | DATA_W'(wtf));
        add_write(REG_MASK,    ($urandom << MASK_W) | DATA_W'(mask));
        for (int ix = int'(REG_MASK) + 1; ix < (1 << REG_IX_W); ix++) begin
            add_write(REG_IX_W'(ix), $urandom);
        end
    endfunction

    // Drop valid and wait until the block has nothing left in flight
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_presses.size() != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    // Setup and access phases; bus left selected for a following write
    task automatic write_register(input logic [REG_IX_W-1:0] ix,
                                  input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ix, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        note_register_write(ix, value);
        writes_done++;
        @(negedge i_clk);
    endtask

    // Offer one beat, hold it until accepted, then record what it should cause
    task automatic send_item(input logic req, input logic [BTN_W-1:0] idx,
                             input logic lvl, input t_chk_kind chk,
                             input logic exp_pressed);
        logic has_result;
        logic pressed;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_button_index <= idx;
        i_level        <= lvl;
        do @(posedge i_clk); while (o_in_stall);
        qualify_press(req, idx, lvl, has_result, pressed);
        if (has_result) begin
            expected_presses.push_back('{button: idx,
                pressed: (chk == CHK_TYPED) ? exp_pressed : pressed});
        end
        items_sent++;
        if (req == REQ_TICK) ticks_sent++;
        @(negedge i_clk);
    endtask

    // Walk the queued rows: settings only once the block is idle
    task automatic walk_rows();
        logic bus_held;
        bus_held = 1'b0;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WRITE) begin
                if (!bus_held) settle();
                write_register(stim_rows[i].reg_ix, stim_rows[i].value);
                bus_held = 1'b1;
            end else begin
                if (bus_held) begin
                    psel     <= 1'b0;
                    penable  <= 1'b0;
                    pwrite   <= 1'b0;
                    bus_held = 1'b0;
                end
                send_item(stim_rows[i].req, stim_rows[i].idx, stim_rows[i].lvl,
                          stim_rows[i].chk, stim_rows[i].exp_pressed);
            end
        end
        if (bus_held) begin
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
        stim_rows.delete();
    endtask

    // Receiver stall: random per phase, forced high during the hold-off
    always @(negedge i_clk) begin
        i_out_stall <= hold_active || ($urandom_range(99) < stall_pct);
    end

    // Hold off the receiver for a long stretch while the sender keeps offering
    initial begin
        wait (items_sent >= HOLD_AT_ITEM);
        @(posedge i_clk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active = 1'b0;
    end

    // Compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_press want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_pressed) presses_seen++;
            if (expected_presses.size() == 0) begin
                check_failures++;
                if (check_failures <= MAX_REPORTS) begin
                    $display("%0t: result button %0d pressed %0b with nothing expected",
                             $time, o_result_button, o_pressed);
                end
            end else begin
                want = expected_presses.pop_front();
                if (o_result_button !== want.button || o_pressed !== want.pressed) begin
                    check_failures++;
                    if (check_failures <= MAX_REPORTS) begin
                        $display({"%0t: expected button %0d pressed %0b, ",
                                  "got button %0d pressed %0b"},
                                 $time, want.button, want.pressed,
                                 o_result_button, o_pressed);
                    end
                end
            end
        end
    end

    // Stop the run when no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a beat", quiet_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0]  rcs;
        logic [CFG_W-1:0]  rcf;
        logic [CFG_W-1:0]  wts;
        logic [CFG_W-1:0]  wtf;
        logic [MASK_W-1:0] mask;
        int                waited;

        for (int b = 0; b < NUM_BUTTONS; b++) begin
            count_left[b] = '0;
            wait_left[b]  = '0;
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table, reset settings first: every button fast, count 1, wait 20
        // a tick with all timers at zero leaves them at zero
        add_item(REQ_TICK,   0, 1'b1, CHK_MODEL, 1'b0);
        // a first press after reset qualifies at once
        add_item(REQ_SAMPLE, 0, 1'b0, CHK_TYPED, 1'b1);
        add_item(REQ_SAMPLE, 7, 1'b0, CHK_TYPED, 1'b1);
        // a released pin never qualifies
        add_item(REQ_SAMPLE, 3, 1'b1, CHK_TYPED, 1'b0);
        // held press while the wait timer still runs
        add_item(REQ_SAMPLE, 0, 1'b0, CHK_MODEL, 1'b0);
        // upper buttons slow with zero reloads, lower ones count 2 and wait 1
        add_setting(16'd0, 16'd2, 16'd0, 16'd1, 8'hF0);
        add_item(REQ_SAMPLE, 4, 1'b0, CHK_MODEL, 1'b0);
        add_item(REQ_SAMPLE, 4, 1'b0, CHK_MODEL, 1'b0);
        // fast button: press, wait out its tick, count down, then repeat
        add_item(REQ_SAMPLE, 1, 1'b0, CHK_MODEL, 1'b0);
        add_item(REQ_SAMPLE, 1, 1'b0, CHK_MODEL, 1'b0);
        add_item(REQ_TICK,   5, 1'b0, CHK_MODEL, 1'b0);
        add_item(REQ_SAMPLE, 1, 1'b0, CHK_MODEL, 1'b0);
        add_item(REQ_SAMPLE, 1, 1'b0, CHK_MODEL, 1'b0);
        add_item(REQ_SAMPLE, 1, 1'b1, CHK_MODEL, 1'b0);
        add_item(REQ_SAMPLE, 1, 1'b0, CHK_MODEL, 1'b0);
        add_item(REQ_TICK,   2, 1'b1, CHK_MODEL, 1'b0);
        add_item(REQ_TICK,   6, 1'b0, CHK_MODEL, 1'b0);
        // every field at its maximum, all buttons slow
        add_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        add_item(REQ_SAMPLE, 2, 1'b0, CHK_MODEL, 1'b0);
        add_item(REQ_SAMPLE, 2, 1'b0, CHK_MODEL, 1'b0);
        add_item(REQ_SAMPLE, 5, 1'b0, CHK_MODEL, 1'b0);
        add_item(REQ_TICK,   7, 1'b1, CHK_MODEL, 1'b0);
        walk_rows();

        // Random phases: new setting each, idling pattern cycles through four modes
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    rcs = '0; rcf = '0; wts = '0; wtf = '0; mask = '0;
                end
                NUM_PHASES - 2: begin
                    rcs = '1; rcf = '0; wts = '0; wtf = 16'd1; mask = 8'h0F;
                end
                NUM_PHASES - 1: begin
                    rcs = '0; rcf = '0; wts = '1; wtf = '1; mask = 8'hFF;
                end
                default: begin
                    rcs  = CFG_W'($urandom_range(3));
                    rcf  = CFG_W'($urandom_range(2));
                    wts  = CFG_W'($urandom_range(5));
                    wtf  = CFG_W'($urandom_range(3));
                    mask = MASK_W'($urandom_range(255));
                end
            endcase
            add_setting(rcs, rcf, wts, wtf, mask);
            // mostly pressed samples with ticks to run the timers down
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(99) < 35) begin
                    add_item(REQ_TICK, int'($urandom_range(7)), 1'($urandom_range(1)),
                             CHK_MODEL, 1'b0);
                end else begin
                    add_item(REQ_SAMPLE, int'($urandom_range(7)),
                             ($urandom_range(99) < 75) ? 1'b0 : 1'b1, CHK_MODEL, 1'b0);
                end
            end
            case (p % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 48; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 48; end
                default: begin sender_idle_pct = 17; stall_pct = 17; end
            endcase
            walk_rows();
        end

        // Drain outstanding results, then let the pipeline empty
        i_in_valid <= 1'b0;
        for (waited = 0; waited < DRAIN_LIMIT && expected_presses.size() != 0; waited++) begin
            @(negedge i_clk);
        end
        repeat (QUIET_CYCLES) @(negedge i_clk);
        if (expected_presses.size() != 0) begin
            check_failures += expected_presses.size();
            $display("%0d expected results never arrived", expected_presses.size());
        end

        $display("Run covered %0d items (%0d ticks) and %0d register writes over %0d settings",
                 items_sent, ticks_sent, writes_done, NUM_PHASES + 3);
        $display("Checked %0d result beats, %0d of them qualified presses; %0d failures",
                 results_seen, presses_seen, check_failures);
        if (check_failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: pushbutton_debounce_autorepeat.f
+incdir+rtl/core
rtl/core/pbda_pkg.sv
rtl/core/pbda_regs.sv
rtl/core/pushbutton_debounce_autorepeat.sv
test/tb_pushbutton_debounce_autorepeat.sv
